FILE: rtl/hextile_rectangle_decoder_macros.svh
// Assertion macros for the hextile rectangle decoder.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef HEXTILE_RECTANGLE_DECODER_MACROS_SVH
`define HEXTILE_RECTANGLE_DECODER_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define HXT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define HXT_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: rtl/hxt_pkg.sv
// Shared types, constants and functions of the hextile rectangle decoder.
// No dependencies.
package hxt_pkg;

   localparam int COORD_BITS = 16;
   localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

   // Tile flag bits
   localparam int F_RAW = 0;
   localparam int F_BG  = 1;
   localparam int F_FG  = 2;
   localparam int F_ANY = 3;
   localparam int F_COL = 4;

   // Configuration register indexes
   localparam logic [2:0] REG_BPP      = 3'd0;
   localparam logic [2:0] REG_RSHIFT   = 3'd1;
   localparam logic [2:0] REG_GSHIFT   = 3'd2;
   localparam logic [2:0] REG_BSHIFT   = 3'd3;
   localparam logic [2:0] REG_RMASK    = 3'd4;
   localparam logic [2:0] REG_GMASK    = 3'd5;
   localparam logic [2:0] REG_BMASK    = 3'd6;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic KIND_FILL  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_FLAGS, PH_RAW, PH_BG, PH_FG, PH_COUNT, PH_SCOL, PH_SXY, PH_SWH
   } phase_type;

   typedef struct packed {
      logic [2:0]  bpp;
      logic [4:0]  red_shift;
      logic [4:0]  green_shift;
      logic [4:0]  blue_shift;
      logic [15:0] red_mask;
      logic [15:0] green_mask;
      logic [15:0] blue_mask;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [4:0]  fill_width;
      logic [4:0]  fill_height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] pixel_value;
      logic        rect_done;
   } rsp_type;

   // Bytes per pixel after clamping to 1..4
   function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
      if (bpp == 3'd0) return 3'd1;
      if (bpp > 3'd4) return 3'd4;
      return bpp;
   endfunction

   // 16-bit pixel to packed 8:8:8 colour
   function automatic logic [23:0] to_rgb(input logic [31:0] pix, input cfg_type cfg);
      logic [15:0] p;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      p = pix[15:0];
      r = (p >> cfg.red_shift) & cfg.red_mask;
      g = (p >> cfg.green_shift) & cfg.green_mask;
      b = (p >> cfg.blue_shift) & cfg.blue_mask;
      return {r[4:0], 3'b000, g[5:0], 2'b00, b[4:0], 3'b000};
   endfunction

endpackage

FILE: rtl/hxt_parse.sv
// Hextile parse state machine: tile walk, header, raw and subrect decode.
// Depends on hxt_pkg.
module hxt_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              op,
   input  logic [15:0]       rect_left,
   input  logic [15:0]       rect_top,
   input  logic [15:0]       rect_width,
   input  logic [15:0]       rect_height,
   input  logic [7:0]        data_byte,
   input  hxt_pkg::cfg_type  cfg,
   output logic              push,
   output hxt_pkg::rsp_type  item
);

   hxt_pkg::phase_type phase_ff, phase_in;
   logic [15:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [11:0] col_ff, col_in, row_ff, row_in;
   logic [4:0]  flags_ff, flags_in;
   logic [23:0] bg_ff, bg_in, fg_ff, fg_in, sub_ff, sub_in;
   logic [7:0]  left_ff, left_in, spos_ff, spos_in;
   logic [1:0]  seen_ff, seen_in;
   logic [31:0] asm_ff, asm_in;
   logic [3:0]  raw_x_ff, raw_x_in, raw_y_ff, raw_y_in;

   logic [12:0] ncols, nrows;
   logic        last_col, last_row;
   logic [15:0] wrem, hrem;
   logic [4:0]  tw, th;
   logic [31:0] tb_asm;
   logic        tb_done;
   logic        is_bpp2;
   logic [23:0] conv, new_bg;
   logic        do_end;
   logic [3:0]  dx, dy;
   logic [7:0]  left_dec;

   always_comb begin
      ncols    = 13'(({1'b0, width_ff} + 17'd15) >> 4);
      nrows    = 13'(({1'b0, height_ff} + 17'd15) >> 4);
      last_col = ({1'b0, col_ff} + 13'd1) >= ncols;
      last_row = ({1'b0, row_ff} + 13'd1) >= nrows;
      wrem     = width_ff - {col_ff, 4'b0000};
      hrem     = height_ff - {row_ff, 4'b0000};
      tw       = last_col ? wrem[4:0] : 5'd16;
      th       = last_row ? hrem[4:0] : 5'd16;
      tb_asm   = ((seen_ff == 2'd0) ? 32'd0 : asm_ff)
                 | (32'(data_byte) << {seen_ff, 3'b000});
      tb_done  = ({1'b0, seen_ff} + 3'd1) >= hxt_pkg::eff_bpp(cfg.bpp);
      is_bpp2  = hxt_pkg::eff_bpp(cfg.bpp) == 3'd2;
      conv     = hxt_pkg::to_rgb(tb_asm, cfg);
      left_dec = left_ff - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hxt_pkg::PH_IDLE;
         origin_x_ff <= '0; origin_y_ff <= '0; width_ff <= '0; height_ff <= '0;
         col_ff <= '0; row_ff <= '0; flags_ff <= '0;
         bg_ff <= '0; fg_ff <= '0; sub_ff <= '0;
         left_ff <= '0; spos_ff <= '0; seen_ff <= '0; asm_ff <= '0;
         raw_x_ff <= '0; raw_y_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         origin_x_ff <= origin_x_in; origin_y_ff <= origin_y_in;
         width_ff <= width_in; height_ff <= height_in;
         col_ff <= col_in; row_ff <= row_in; flags_ff <= flags_in;
         bg_ff <= bg_in; fg_ff <= fg_in; sub_ff <= sub_in;
         left_ff <= left_in; spos_ff <= spos_in; seen_ff <= seen_in; asm_ff <= asm_in;
         raw_x_ff <= raw_x_in; raw_y_ff <= raw_y_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      origin_x_in = origin_x_ff; origin_y_in = origin_y_ff;
      width_in = width_ff; height_in = height_ff;
      col_in = col_ff; row_in = row_ff; flags_in = flags_ff;
      bg_in = bg_ff; fg_in = fg_ff; sub_in = sub_ff;
      left_in = left_ff; spos_in = spos_ff; seen_in = seen_ff; asm_in = asm_ff;
      raw_x_in = raw_x_ff; raw_y_in = raw_y_ff;
      push = 1'b0;
      do_end = 1'b0;
      dx = 4'd0;
      dy = 4'd0;
      new_bg = bg_ff;
      item.kind = hxt_pkg::KIND_FILL;
      item.fill_width = tw;
      item.fill_height = th;
      item.pixel_value = 32'd0;
      item.rect_done = 1'b0;
      {item.red, item.green, item.blue} = bg_ff;

      if (accept && op == hxt_pkg::OP_START) begin
         origin_x_in = rect_left; origin_y_in = rect_top;
         width_in = rect_width; height_in = rect_height;
         col_in = '0; row_in = '0; flags_in = '0;
         bg_in = '0; fg_in = '0; sub_in = '0;
         left_in = '0; spos_in = '0; seen_in = '0; asm_in = '0;
         raw_x_in = '0; raw_y_in = '0;
         phase_in = (rect_width == 16'd0 || rect_height == 16'd0) ?
                    hxt_pkg::PH_IDLE : hxt_pkg::PH_FLAGS;
      end else if (accept) begin
         case (phase_ff)
            hxt_pkg::PH_FLAGS: begin
               flags_in = data_byte[4:0];
               seen_in = 2'd0;
               if (data_byte[hxt_pkg::F_RAW]) begin
                  raw_x_in = '0; raw_y_in = '0;
                  phase_in = hxt_pkg::PH_RAW;
               end else if (data_byte[hxt_pkg::F_BG]) begin
                  phase_in = hxt_pkg::PH_BG;
               end else if (data_byte[hxt_pkg::F_FG]) begin
                  phase_in = hxt_pkg::PH_FG;
               end else if (data_byte[hxt_pkg::F_ANY]) begin
                  phase_in = hxt_pkg::PH_COUNT;
               end else begin
                  push = 1'b1;
                  do_end = 1'b1;
               end
            end
            hxt_pkg::PH_RAW: begin
               seen_in = tb_done ? 2'd0 : seen_ff + 2'd1;
               asm_in = tb_asm;
               if (tb_done) begin
                  push = 1'b1;
                  item.kind = hxt_pkg::KIND_PIXEL;
                  dx = raw_x_ff; dy = raw_y_ff;
                  item.fill_width = 5'd1; item.fill_height = 5'd1;
                  {item.red, item.green, item.blue} = 24'd0;
                  item.pixel_value = tb_asm;
                  if ({1'b0, raw_x_ff} == tw - 5'd1) begin
                     if ({1'b0, raw_y_ff} == th - 5'd1) begin
                        do_end = 1'b1;
                     end else begin
                        raw_x_in = '0;
                        raw_y_in = raw_y_ff + 4'd1;
                     end
                  end else begin
                     raw_x_in = raw_x_ff + 4'd1;
                  end
               end
            end
            hxt_pkg::PH_BG: begin
               seen_in = tb_done ? 2'd0 : seen_ff + 2'd1;
               asm_in = tb_asm;
               if (tb_done) begin
                  new_bg = is_bpp2 ? conv : bg_ff;
                  bg_in = new_bg;
                  if (flags_ff[hxt_pkg::F_FG]) begin
                     phase_in = hxt_pkg::PH_FG;
                  end else if (flags_ff[hxt_pkg::F_ANY]) begin
                     phase_in = hxt_pkg::PH_COUNT;
                  end else begin
                     push = 1'b1;
                     {item.red, item.green, item.blue} = new_bg;
                     do_end = 1'b1;
                  end
               end
            end
            hxt_pkg::PH_FG: begin
               seen_in = tb_done ? 2'd0 : seen_ff + 2'd1;
               asm_in = tb_asm;
               if (tb_done) begin
                  fg_in = is_bpp2 ? conv : fg_ff;
                  if (flags_ff[hxt_pkg::F_ANY]) begin
                     phase_in = hxt_pkg::PH_COUNT;
                  end else begin
                     push = 1'b1;
                     do_end = 1'b1;
                  end
               end
            end
            hxt_pkg::PH_COUNT: begin
               left_in = data_byte;
               push = 1'b1;
               if (data_byte == 8'd0) begin
                  do_end = 1'b1;
               end else begin
                  phase_in = flags_ff[hxt_pkg::F_COL] ? hxt_pkg::PH_SCOL : hxt_pkg::PH_SXY;
               end
            end
            hxt_pkg::PH_SCOL: begin
               seen_in = tb_done ? 2'd0 : seen_ff + 2'd1;
               asm_in = tb_asm;
               if (tb_done) begin
                  sub_in = is_bpp2 ? conv : sub_ff;
                  phase_in = hxt_pkg::PH_SXY;
               end
            end
            hxt_pkg::PH_SXY: begin
               spos_in = data_byte;
               phase_in = hxt_pkg::PH_SWH;
            end
            hxt_pkg::PH_SWH: begin
               push = 1'b1;
               dx = spos_ff[7:4]; dy = spos_ff[3:0];
               item.fill_width = {1'b0, data_byte[7:4]} + 5'd1;
               item.fill_height = {1'b0, data_byte[3:0]} + 5'd1;
               {item.red, item.green, item.blue} = flags_ff[hxt_pkg::F_COL] ? sub_ff : fg_ff;
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  do_end = 1'b1;
               end else begin
                  phase_in = flags_ff[hxt_pkg::F_COL] ? hxt_pkg::PH_SCOL : hxt_pkg::PH_SXY;
               end
            end
            default: begin
            end
         endcase

         // Finish the tile: advance the walk or close the rectangle
         if (do_end) begin
            if (last_col && last_row) begin
               phase_in = hxt_pkg::PH_IDLE;
               item.rect_done = 1'b1;
            end else begin
               phase_in = hxt_pkg::PH_FLAGS;
               if (last_col) begin
                  col_in = '0;
                  row_in = row_ff + 12'd1;
               end else begin
                  col_in = col_ff + 12'd1;
               end
            end
         end
      end

      item.pos_x = (origin_x_ff + {col_ff, 4'b0000} + {12'd0, dx}) & hxt_pkg::COORD_MASK;
      item.pos_y = (origin_y_ff + {row_ff, 4'b0000} + {12'd0, dy}) & hxt_pkg::COORD_MASK;
   end

endmodule

FILE: rtl/hxt_outbuf.sv
// Result register with one skid entry, decoupling the parser from rsp_stall.
// Depends on hxt_pkg and the assertion macro header.
`include "hextile_rectangle_decoder_macros.svh"
module hxt_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hxt_pkg::rsp_type item,
   input  logic             out_stall,
   output logic             out_valid,
   output hxt_pkg::rsp_type out_item,
   output logic             full
);

   logic             out_valid_ff, skid_valid_ff;
   hxt_pkg::rsp_type out_ff, skid_ff;
   logic             pop;

   assign pop       = out_valid_ff && !out_stall;
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
   assign full      = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= item;
         end else begin
            skid_ff <= item;
         end
      end
   end

   `HXT_ASSERT(a_skid_needs_out, !skid_valid_ff || out_valid_ff, "skid filled while output empty")
   `HXT_ASSERT(a_no_push_when_full, !(push && skid_valid_ff), "result pushed into full buffer")
   `HXT_ASSERT_NEXT(a_stalled_kept, out_valid_ff && out_stall, out_valid_ff, "stalled result lost")

endmodule

FILE: rtl/hextile_rectangle_decoder.sv
// Top level of the hextile rectangle decoder: CSR block, parser, result buffer.
// Depends on hxt_pkg, hxt_parse and hxt_outbuf.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   req      | req_valid/req_stall | op, rect geometry, data_byte
//   rsp      | rsp_valid/rsp_stall | kind, pos, fill size, colour, pixel, done
//   csr      | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request transfer per cycle unless req_stall is high; each byte is parsed
// in the cycle it arrives. A result is registered before it appears on rsp.
// The result register plus one skid entry absorb rsp_stall; req_stall rises
// only while the skid entry is occupied.
// Synchronous active-high reset returns to idle with the default pixel format.
// csr writes are always taken (csr_ready is tied high).
module hextile_rectangle_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_rect_left,
   input  logic [15:0] req_rect_top,
   input  logic [15:0] req_rect_width,
   input  logic [15:0] req_rect_height,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [4:0]  rsp_fill_width,
   output logic [4:0]  rsp_fill_height,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [31:0] rsp_pixel_value,
   output logic        rsp_rect_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   hxt_pkg::cfg_type cfg_ff;
   hxt_pkg::rsp_type item, out_item;
   logic             accept, push, full;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   // Configuration registers; reset to 16-bit 5:6:5 pixels
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bpp         <= 3'd2;
         cfg_ff.red_shift   <= 5'd11;
         cfg_ff.green_shift <= 5'd5;
         cfg_ff.blue_shift  <= 5'd0;
         cfg_ff.red_mask    <= 16'd31;
         cfg_ff.green_mask  <= 16'd63;
         cfg_ff.blue_mask   <= 16'd31;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hxt_pkg::REG_BPP:    cfg_ff.bpp         <= csr_wdata[2:0];
            hxt_pkg::REG_RSHIFT: cfg_ff.red_shift   <= csr_wdata[4:0];
            hxt_pkg::REG_GSHIFT: cfg_ff.green_shift <= csr_wdata[4:0];
            hxt_pkg::REG_BSHIFT: cfg_ff.blue_shift  <= csr_wdata[4:0];
            hxt_pkg::REG_RMASK:  cfg_ff.red_mask    <= csr_wdata;
            hxt_pkg::REG_GMASK:  cfg_ff.green_mask  <= csr_wdata;
            hxt_pkg::REG_BMASK:  cfg_ff.blue_mask   <= csr_wdata;
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   hxt_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .data_byte   (req_data_byte),
      .cfg         (cfg_ff),
      .push        (push),
      .item        (item)
   );

   hxt_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item      (item),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (out_item),
      .full      (full)
   );

   assign rsp_kind        = out_item.kind;
   assign rsp_pos_x       = out_item.pos_x;
   assign rsp_pos_y       = out_item.pos_y;
   assign rsp_fill_width  = out_item.fill_width;
   assign rsp_fill_height = out_item.fill_height;
   assign rsp_red         = out_item.red;
   assign rsp_green       = out_item.green;
   assign rsp_blue        = out_item.blue;
   assign rsp_pixel_value = out_item.pixel_value;
   assign rsp_rect_done   = out_item.rect_done;

endmodule

FILE: tb/tb_hextile_rectangle_decoder.sv
// Self-checking testbench for the hextile rectangle decoder.
// Depends on hxt_pkg and the hextile_rectangle_decoder RTL.
module tb_hextile_rectangle_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import hxt_pkg::*;

   localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer before giving up
   localparam int SETTLE_TICKS = 12;     // results pass the result register; keep margin
   localparam int ITEM_TARGET  = 600;

   // Tile decoder predictor: tracks parse state and queues the fills and pixels
   // that each accepted transfer must produce.
   class tile_decode_model;
      cfg_type     cfg;
      phase_type   phase;
      int unsigned ox, oy, tot_w, tot_h, col, row, nbytes, raw_idx, left;
      logic [4:0]  flags;
      logic [23:0] bg, fg, sub_rgb;
      logic [7:0]  sub_pos;
      logic [31:0] asm_pix;
      rsp_type     pending_results[$];
      int          errors;

      function new();
         cfg = '{bpp: 3'd2, red_shift: 5'd11, green_shift: 5'd5, blue_shift: 5'd0,
                 red_mask: 16'd31, green_mask: 16'd63, blue_mask: 16'd31};
         phase = PH_IDLE;
         {ox, oy, tot_w, tot_h, col, row, nbytes, raw_idx, left} = '0;
         flags = '0; bg = '0; fg = '0; sub_rgb = '0; sub_pos = '0; asm_pix = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            REG_BPP:    cfg.bpp = val[2:0];
            REG_RSHIFT: cfg.red_shift = val[4:0];
            REG_GSHIFT: cfg.green_shift = val[4:0];
            REG_BSHIFT: cfg.blue_shift = val[4:0];
            REG_RMASK:  cfg.red_mask = val;
            REG_GMASK:  cfg.green_mask = val;
            REG_BMASK:  cfg.blue_mask = val;
            default: ;
         endcase
      endfunction

      // Clamp depth: zero behaves as one, above four as four.
      function int unsigned pixel_bytes();
         if (cfg.bpp == 0) return 1;
         if (cfg.bpp > 4) return 4;
         return cfg.bpp;
      endfunction

      function int unsigned tile_cols();
         return (tot_w + 15) / 16;
      endfunction

      function int unsigned tile_rows();
         return (tot_h + 15) / 16;
      endfunction

      // Close the tile; return 1 when it was the last of the rectangle.
      function bit finish_tile();
         if (col + 1 >= tile_cols() && row + 1 >= tile_rows()) begin
            phase = PH_IDLE;
            return 1'b1;
         end
         col++;
         if (col >= tile_cols()) begin
            col = 0;
            row++;
         end
         phase = PH_FLAGS;
         return 1'b0;
      endfunction

      // Little-endian pixel assembly; return 1 when the pixel is complete.
      function bit gather(logic [7:0] b);
         if (nbytes == 0) asm_pix = '0;
         asm_pix |= 32'(b) << (8 * nbytes);
         nbytes++;
         if (nbytes >= pixel_bytes()) begin
            nbytes = 0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // Only 16-bit pixels are converted; other depths hold the old colour.
      function logic [23:0] convert(logic [23:0] prev);
         logic [31:0] p, r, g, b;
         if (pixel_bytes() != 2) return prev;
         p = {16'd0, asm_pix[15:0]};
         r = ((p >> cfg.red_shift) & {16'd0, cfg.red_mask}) << 3;
         g = ((p >> cfg.green_shift) & {16'd0, cfg.green_mask}) << 2;
         b = ((p >> cfg.blue_shift) & {16'd0, cfg.blue_mask}) << 3;
         return {r[7:0], g[7:0], b[7:0]};
      endfunction

      function rsp_type make(logic kind, int unsigned dx, int unsigned dy, int unsigned w,
                             int unsigned h, logic [23:0] rgb, logic [31:0] pix);
         rsp_type r;
         r.kind        = kind;
         r.pos_x       = 16'(ox + col * 16 + dx);
         r.pos_y       = 16'(oy + row * 16 + dy);
         r.fill_width  = 5'(w);
         r.fill_height = 5'(h);
         {r.red, r.green, r.blue} = rgb;
         r.pixel_value = pix;
         r.rect_done   = 1'b0;
         return r;
      endfunction

      function void accept_item(logic op, logic [15:0] l, logic [15:0] t, logic [15:0] w,
                                logic [15:0] h, logic [7:0] b);
         rsp_type     r;
         int unsigned tw, th;
         if (op == OP_START) begin
            ox = l; oy = t; tot_w = w; tot_h = h;
            col = 0; row = 0; flags = '0;
            bg = '0; fg = '0; sub_rgb = '0;
            left = 0; sub_pos = '0; nbytes = 0; asm_pix = '0; raw_idx = 0;
            phase = (w == 0 || h == 0) ? PH_IDLE : PH_FLAGS;
            return;
         end
         tw = (col + 1 >= tile_cols()) ? tot_w - 16 * col : 16;
         th = (row + 1 >= tile_rows()) ? tot_h - 16 * row : 16;
         case (phase)
            PH_FLAGS: begin
               flags  = b[4:0];
               nbytes = 0;
               if (flags[F_RAW]) begin
                  raw_idx = 0;
                  phase = PH_RAW;
               end else if (flags[F_BG]) begin
                  phase = PH_BG;
               end else if (flags[F_FG]) begin
                  phase = PH_FG;
               end else if (flags[F_ANY]) begin
                  phase = PH_COUNT;
               end else begin
                  r = make(KIND_FILL, 0, 0, tw, th, bg, '0);
                  r.rect_done = finish_tile();
                  pending_results.push_back(r);
               end
            end
            PH_RAW: begin
               if (gather(b)) begin
                  r = make(KIND_PIXEL, raw_idx % tw, raw_idx / tw, 1, 1, '0, asm_pix);
                  if (raw_idx + 1 >= tw * th) r.rect_done = finish_tile();
                  else raw_idx = (raw_idx + 1) & 255;
                  pending_results.push_back(r);
               end
            end
            PH_BG, PH_FG: begin
               if (gather(b)) begin
                  if (phase == PH_BG) bg = convert(bg);
                  else fg = convert(fg);
                  if (phase == PH_BG && flags[F_FG]) begin
                     phase = PH_FG;
                  end else if (flags[F_ANY]) begin
                     phase = PH_COUNT;
                  end else begin
                     r = make(KIND_FILL, 0, 0, tw, th, bg, '0);
                     r.rect_done = finish_tile();
                     pending_results.push_back(r);
                  end
               end
            end
            PH_COUNT: begin
               left = b;
               r = make(KIND_FILL, 0, 0, tw, th, bg, '0);
               if (b == 0) r.rect_done = finish_tile();
               else phase = flags[F_COL] ? PH_SCOL : PH_SXY;
               pending_results.push_back(r);
            end
            PH_SCOL: begin
               if (gather(b)) begin
                  sub_rgb = convert(sub_rgb);
                  phase = PH_SXY;
               end
            end
            PH_SXY: begin
               sub_pos = b;
               phase = PH_SWH;
            end
            PH_SWH: begin
               r = make(KIND_FILL, sub_pos[7:4], sub_pos[3:0], b[7:4] + 1, b[3:0] + 1,
                        flags[F_COL] ? sub_rgb : fg, '0);
               left = (left - 1) & 255;
               if (left == 0) r.rect_done = finish_tile();
               else phase = flags[F_COL] ? PH_SCOL : PH_SXY;
               pending_results.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("fill_width", want.fill_width, got.fill_width);
         compare_field("fill_height", want.fill_height, got.fill_height);
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("pixel_value", want.pixel_value, got.pixel_value);
         compare_field("rect_done", want.rect_done, got.rect_done);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_START;
   logic [15:0] req_rect_left = '0;
   logic [15:0] req_rect_top = '0;
   logic [15:0] req_rect_width = '0;
   logic [15:0] req_rect_height = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_pos_x, rsp_pos_y;
   logic [4:0]  rsp_fill_width, rsp_fill_height;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic [31:0] rsp_pixel_value;
   logic        rsp_rect_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_BPP;
   logic [15:0] csr_wdata = '0;

   tile_decode_model model = new();
   int          items_sent = 0;
   int          idle_ticks = 0;

   hextile_rectangle_decoder i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; zero means no gap at all.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver back-pressure: random stall bursts, with occasional long clean runs.
   initial begin
      int n;
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Check every result transfer against the oldest queued expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.match_result('{rsp_kind, rsp_pos_x, rsp_pos_y, rsp_fill_width,
                              rsp_fill_height, rsp_red, rsp_green, rsp_blue,
                              rsp_pixel_value, rsp_rect_done});
   end

   // Watchdog: give up when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_ticks <= 0;
      else
         idle_ticks <= idle_ticks + 1;
      if (idle_ticks >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Present one request, hold it until taken, then maybe drop valid for a gap.
   task automatic push_item(logic op, logic [15:0] l, logic [15:0] t, logic [15:0] w,
                            logic [15:0] h, logic [7:0] b);
      int n;
      req_op          <= op;
      req_rect_left   <= l;
      req_rect_top    <= t;
      req_rect_width  <= w;
      req_rect_height <= h;
      req_data_byte   <= b;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.accept_item(op, l, t, w, h, b);
      items_sent++;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic start_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h);
      push_item(OP_START, l, t, w, h, 8'($urandom));
   endtask

   // Data transfer; geometry lines carry junk that must be ignored.
   task automatic send_byte(logic [7:0] b);
      push_item(OP_DATA, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), b);
   endtask

   task automatic send_pixel(logic [31:0] v);
      for (int i = 0; i < model.pixel_bytes(); i++) send_byte(v[8 * i +: 8]);
   endtask

   // Drain outstanding results, then let the pipeline settle before touching CSRs.
   task automatic drain();
      while (model.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_format(logic [2:0] bpp, logic [4:0] rs, logic [4:0] gs,
                                 logic [4:0] bs, logic [15:0] rm, logic [15:0] gm,
                                 logic [15:0] bm);
      req_valid <= 1'b0;
      drain();
      write_csr(REG_BPP, {13'd0, bpp});
      write_csr(REG_RSHIFT, {11'd0, rs});
      write_csr(REG_GSHIFT, {11'd0, gs});
      write_csr(REG_BSHIFT, {11'd0, bs});
      write_csr(REG_RMASK, rm);
      write_csr(REG_GMASK, gm);
      write_csr(REG_BMASK, bm);
   endtask

   // Encode one well-formed tile with random content.
   task automatic play_tile(int unsigned tw, int unsigned th);
      logic [7:0] fl;
      int         cnt;
      if ($urandom_range(0, 9) < 2 && tw * th <= 48) begin
         // raw tile: upper flag bits are don't-care
         send_byte({3'($urandom), 4'($urandom), 1'b1});
         repeat (tw * th) send_pixel($urandom);
         return;
      end
      fl = {3'($urandom), 4'($urandom), 1'b0};
      send_byte(fl);
      if (fl[F_BG]) send_pixel($urandom);
      if (fl[F_FG]) send_pixel($urandom);
      if (fl[F_ANY]) begin
         cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         send_byte(8'(cnt));
         repeat (cnt) begin
            if (fl[F_COL]) send_pixel($urandom);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end
      end
   endtask

   // One rectangle; a few are cut short so the next start abandons them.
   task automatic play_rect();
      int unsigned w, h, nc, nr, tw, th;
      bit          cut;
      w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 36) : $urandom_range(37, 64);
      h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 48);
      cut = ($urandom_range(0, 99) < 8);
      nc = (w + 15) / 16;
      nr = (h + 15) / 16;
      start_rect(16'($urandom), 16'($urandom), 16'(w), 16'(h));
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            tw = (c == nc - 1) ? w - 16 * c : 16;
            th = (r == nr - 1) ? h - 16 * r : 16;
            if (cut && $urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
               return;
            end
            play_tile(tw, th);
         end
      end
      // stray bytes after the rectangle is complete are ignored
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
   endtask

   initial begin
      logic [2:0] depth[7];
      depth = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd2, 3'd2};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: wrapping coordinates, every tile type, idle and abandon cases.
      send_byte(8'hFF);                         // data while idle: ignore
      start_rect(16'hFFF8, 16'hFFF8, 16'd16, 16'd16);
      send_byte(8'h00);                         // plain fill with background
      start_rect(16'd100, 16'd200, 16'd3, 16'd2);
      send_byte(8'h1F);                         // raw with every other flag set
      repeat (6) send_pixel($urandom);
      start_rect(16'd0, 16'd0, 16'd17, 16'd1);
      send_byte(8'h0E);                         // background, foreground, zero subrects
      send_pixel(32'hFFFF);
      send_pixel(32'h0000);
      send_byte(8'h00);
      send_byte(8'h18);                         // one coloured subrect outside the tile
      send_byte(8'h01);
      send_pixel(32'hF81F);
      send_byte(8'hFF);
      send_byte(8'hFF);
      start_rect(16'h1234, 16'h5678, 16'd0, 16'd5);       // empty: stays idle
      send_byte(8'h00);
      start_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // abandoned below
      send_byte(8'h02);
      start_rect(16'd7, 16'd9, 16'd1, 16'd1);
      send_byte(8'h02);                         // background only
      send_pixel(32'h07E0);

      // Random: walk through pixel formats, extremes first.
      for (int p = 0; p < 8 && items_sent < ITEM_TARGET; p++) begin
         start_rect('0, '0, '0, '0);          // force idle before reprogramming
         if (p == 0)
            program_format(3'd2, 5'd0, 5'd0, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else if (p == 1)
            program_format(3'd2, 5'd31, 5'd31, 5'd31, 16'h0000, 16'h0000, 16'h0000);
         else
            program_format(depth[p - 1], 5'($urandom), 5'($urandom), 5'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
         while (items_sent < ITEM_TARGET * (p + 1) / 8) play_rect();
      end
      req_valid <= 1'b0;

      drain();
      if (model.errors == 0 && model.pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
